// ----- src/scfc_pkg.sv -----
package scfc_pkg;

   // Frame layout
   localparam int FRAME_BYTES   = 23;
   localparam int OFS_ROAD_ERR  = 6;
   localparam int OFS_ROAD_TEMP = 7;
   localparam int OFS_ROAD_COND = 11;
   localparam int OFS_AIR_ERR   = 12;
   localparam int OFS_AIR_TEMP  = 13;
   localparam int OFS_AIR_HUMI  = 17;
   localparam int OFS_CRC       = 21;

   // Only offsets from the road error byte up are ever read
   localparam int CAP_FIRST = OFS_ROAD_ERR;
   localparam int CAP_BYTES = FRAME_BYTES - CAP_FIRST;

   // Default longest frame that is still captured and checked
   localparam int MAX_FRAME_DEF = 64;

   // CRC-16/Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Status byte reported when the CRC check fails
   localparam logic [7:0] STATUS_CRC_FAIL = 8'h01;

   // Frame contents after the current byte, before the end-of-frame reload
   typedef struct packed {
      logic [15:0] crc;
      logic [15:0] stored_crc;
      logic [7:0]  road_fault;
      logic [31:0] road_temp;
      logic [7:0]  road_cond;
      logic [7:0]  air_fault;
      logic [31:0] air_temp;
      logic [31:0] air_humi;
   } frame_view_type;

   // One byte through the reflected CRC, bit by bit
   function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

// ----- src/sensor_frame_crc_checker_top.sv -----
// The result is registered and appears on rsp in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle when ready; the CRC update and capture share one cycle.
// rsp is a single output register; req_tready drops only while a result waits.
// Reset (synchronous, active high) reloads the frame state (CRC 0xFFFF, empty frame)
// and clears the held sensor values and the output valid.
module sensor_frame_crc_checker_top #(
   parameter int MAX_FRAME = scfc_pkg::MAX_FRAME_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // [7:0] air_status, [15:8] road_status,
                                     // [47:16] air_temp_bits, [79:48] air_humidity_bits,
                                     // [111:80] road_temp_bits, [119:112] road_state
   output logic         rsp_tuser    // crc_ok
);
   import scfc_pkg::*;

   frame_view_type view;
   logic           byte_take;
   logic           crc_match;
   logic [7:0]     air_status, road_status;

   logic [31:0] air_temp_ff, air_temp_in;
   logic [31:0] air_humi_ff, air_humi_in;
   logic [31:0] road_temp_ff, road_temp_in;
   logic [7:0]  road_state_ff, road_state_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [119:0] rsp_data_ff, rsp_data_in;
   logic         rsp_ok_ff, rsp_ok_in;

   // Input side moves whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign byte_take  = req_tvalid && req_tready;

   scfc_frame_track #(
      .MAX_FRAME (MAX_FRAME)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_tdata),
      .last_byte (req_tlast),
      .view      (view)
   );

   // CRC check and status selection
   assign crc_match   = (view.stored_crc == view.crc);
   assign air_status  = crc_match ? view.air_fault  : STATUS_CRC_FAIL;
   assign road_status = crc_match ? view.road_fault : STATUS_CRC_FAIL;

   // Held values follow a good frame per sensor
   always_comb begin
      air_temp_in   = air_temp_ff;
      air_humi_in   = air_humi_ff;
      road_temp_in  = road_temp_ff;
      road_state_in = road_state_ff;
      if (byte_take && req_tlast && crc_match) begin
         if (view.air_fault == 8'h00) begin
            air_temp_in = view.air_temp;
            air_humi_in = view.air_humi;
         end
         if (view.road_fault == 8'h00) begin
            road_temp_in  = view.road_temp;
            road_state_in = view.road_cond;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (byte_take && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = crc_match;
         rsp_data_in  = {road_state_in, road_temp_in, air_humi_in, air_temp_in,
                         road_status, air_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         air_temp_ff   <= '0;
         air_humi_ff   <= '0;
         road_temp_ff  <= '0;
         road_state_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         air_temp_ff   <= air_temp_in;
         air_humi_ff   <= air_humi_in;
         road_temp_ff  <= road_temp_in;
         road_state_ff <= road_state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // Checks
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      byte_take && req_tlast |=> rsp_tvalid)
      else $error("last byte transfer did not produce a result");

   a_fail_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[7:0] == STATUS_CRC_FAIL) && (rsp_tdata[15:8] == STATUS_CRC_FAIL))
      else $error("CRC failure reported without failure status");

   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      !(byte_take && req_tlast) |=> $stable(road_state_ff) && $stable(air_temp_ff))
      else $error("held values changed outside an end of frame");

   a_fail_keeps_held: assert property (@(posedge clock) disable iff (reset)
      byte_take && req_tlast && !crc_match |=> $stable(air_humi_ff) && $stable(road_temp_ff))
      else $error("held values changed on a CRC failure");

endmodule

// ----- src/scfc_frame_track.sv -----
module scfc_frame_track #(
   parameter int MAX_FRAME = scfc_pkg::MAX_FRAME_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_take,   // a byte transfer at this edge
   input  logic [7:0]                rx_byte,
   input  logic                      last_byte,
   output scfc_pkg::frame_view_type  view
);
   import scfc_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME + 1);

   logic [IDX_W-1:0] idx_ff, idx_in, idx_nx;
   logic [15:0]      crc_ff, crc_in, crc_nx;
   logic [7:0]       dly0_ff, dly0_in, dly0_nx;
   logic [7:0]       dly1_ff, dly1_in, dly1_nx;
   logic [7:0]       cap_ff [CAP_BYTES];
   logic [7:0]       cap_in [CAP_BYTES];
   logic [7:0]       cap_nx [CAP_BYTES];

   // Frame state after taking this byte
   always_comb begin
      idx_nx  = idx_ff;
      crc_nx  = crc_ff;
      dly0_nx = dly0_ff;
      dly1_nx = dly1_ff;
      for (int k = 0; k < CAP_BYTES; k++) begin
         cap_nx[k] = cap_ff[k];
      end
      if (idx_ff < IDX_W'(MAX_FRAME)) begin
         // the two newest bytes are held back from the CRC
         if (idx_ff >= IDX_W'(2)) begin
            crc_nx = crc_feed(crc_ff, dly0_ff);
         end
         dly0_nx = dly1_ff;
         dly1_nx = rx_byte;
         for (int k = 0; k < CAP_BYTES; k++) begin
            if (idx_ff == IDX_W'(k + CAP_FIRST)) begin
               cap_nx[k] = rx_byte;
            end
         end
         idx_nx = idx_ff + IDX_W'(1);
      end
   end

   // Advance on a transfer, reload after the last byte
   always_comb begin
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      dly0_in = dly0_ff;
      dly1_in = dly1_ff;
      for (int k = 0; k < CAP_BYTES; k++) begin
         cap_in[k] = cap_ff[k];
      end
      if (byte_take) begin
         if (last_byte) begin
            idx_in  = '0;
            crc_in  = CRC_INIT;
            dly0_in = '0;
            dly1_in = '0;
            for (int k = 0; k < CAP_BYTES; k++) begin
               cap_in[k] = '0;
            end
         end else begin
            idx_in  = idx_nx;
            crc_in  = crc_nx;
            dly0_in = dly0_nx;
            dly1_in = dly1_nx;
            for (int k = 0; k < CAP_BYTES; k++) begin
               cap_in[k] = cap_nx[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         crc_ff  <= CRC_INIT;
         dly0_ff <= '0;
         dly1_ff <= '0;
         for (int k = 0; k < CAP_BYTES; k++) begin
            cap_ff[k] <= '0;
         end
      end else begin
         idx_ff  <= idx_in;
         crc_ff  <= crc_in;
         dly0_ff <= dly0_in;
         dly1_ff <= dly1_in;
         for (int k = 0; k < CAP_BYTES; k++) begin
            cap_ff[k] <= cap_in[k];
         end
      end
   end

   // Fixed-offset fields, little-endian
   assign view.crc        = crc_nx;
   assign view.stored_crc = {cap_nx[OFS_CRC + 1 - CAP_FIRST], cap_nx[OFS_CRC - CAP_FIRST]};
   assign view.road_fault = cap_nx[OFS_ROAD_ERR - CAP_FIRST];
   assign view.road_temp  = {cap_nx[OFS_ROAD_TEMP + 3 - CAP_FIRST],
                             cap_nx[OFS_ROAD_TEMP + 2 - CAP_FIRST],
                             cap_nx[OFS_ROAD_TEMP + 1 - CAP_FIRST],
                             cap_nx[OFS_ROAD_TEMP - CAP_FIRST]};
   assign view.road_cond  = cap_nx[OFS_ROAD_COND - CAP_FIRST];
   assign view.air_fault  = cap_nx[OFS_AIR_ERR - CAP_FIRST];
   assign view.air_temp   = {cap_nx[OFS_AIR_TEMP + 3 - CAP_FIRST],
                             cap_nx[OFS_AIR_TEMP + 2 - CAP_FIRST],
                             cap_nx[OFS_AIR_TEMP + 1 - CAP_FIRST],
                             cap_nx[OFS_AIR_TEMP - CAP_FIRST]};
   assign view.air_humi   = {cap_nx[OFS_AIR_HUMI + 3 - CAP_FIRST],
                             cap_nx[OFS_AIR_HUMI + 2 - CAP_FIRST],
                             cap_nx[OFS_AIR_HUMI + 1 - CAP_FIRST],
                             cap_nx[OFS_AIR_HUMI - CAP_FIRST]};

endmodule

// ----- tb/testbench.sv -----
module testbench;
   import scfc_pkg::*;

   localparam int MAX_FRAME    = MAX_FRAME_DEF;
   localparam int RANDOM_BYTES = 1650;
   localparam int PLAN_DEPTH   = 200;
   localparam int LONG_HOLD    = 150;
   localparam int DIRECTED_ROWS = 26;

   // one result, laid out as {rsp_tuser, rsp_tdata}
   typedef struct packed {
      logic        crc_ok;
      logic [7:0]  road_state;
      logic [31:0] road_temp;
      logic [31:0] air_humi;
      logic [31:0] air_temp;
      logic [7:0]  road_status;
      logic [7:0]  air_status;
   } sensor_report_type;

   // one byte transfer on req, with an optional typed-in result
   typedef struct {
      logic [7:0]        data;
      logic              last;
      bit                typed;
      sensor_report_type exp;
   } rx_item_type;

   // where a directed row takes its byte from
   typedef enum logic [1:0] {SRC_BYTE, SRC_CRC_LO, SRC_CRC_HI} row_src_type;

   typedef struct {
      logic [7:0]        data;
      logic              last;
      row_src_type       src;
      bit                typed;
      sensor_report_type exp;
   } directed_row_type;

   typedef enum logic [2:0] {FR_GOOD, FR_CORRUPT, FR_SHORT, FR_LONG, FR_TAIL} frame_kind_type;

   // receiver stall patterns
   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_type;

   // after reset the held values are all zero, so a failed frame reads back like this
   localparam sensor_report_type CRC_FAIL_EMPTY = '{crc_ok: 1'b0,
                                                    road_status: STATUS_CRC_FAIL,
                                                    air_status: STATUS_CRC_FAIL,
                                                    default: '0};
   localparam sensor_report_type GOOD_FRAME_EXP = '{crc_ok: 1'b1,
                                                    road_state: 8'hFF,
                                                    road_temp: 32'h80030201,
                                                    air_humi: 32'h78563412,
                                                    air_temp: 32'hFFFFFFFF,
                                                    road_status: 8'h00,
                                                    air_status: 8'h00};
   localparam sensor_report_type NO_REPORT = '0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] rx_byte
   logic         req_tlast = 1'b0;    // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;           // [7:0] air_status, [15:8] road_status,
                                      // [47:16] air_temp_bits, [79:48] air_humidity_bits,
                                      // [111:80] road_temp_bits, [119:112] road_state
   logic         rsp_tuser;           // crc_ok

   sensor_frame_crc_checker_top #(
      .MAX_FRAME(MAX_FRAME)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stimulus and bookkeeping
   rx_item_type       byte_plan[$];
   sensor_report_type expected_reports[$];
   logic [7:0]        frame_bytes[$];
   directed_row_type  directed_rows[DIRECTED_ROWS];
   int             bytes_planned   = 0;
   int             bytes_accepted  = 0;
   int             frames_planned  = 0;
   int             mismatch_cnt    = 0;
   int             reports_ok      = 0;
   int             reports_flagged = 0;
   int             long_holds      = 0;
   int             drains          = 0;
   logic           long_stall_req  = 1'b0;

   // predictor state
   logic [15:0] rx_crc;
   int          rx_count;
   logic [7:0]  rx_tail[2];
   logic [7:0]  rx_frame[FRAME_BYTES];
   logic [31:0] last_air_temp;
   logic [31:0] last_air_humi;
   logic [31:0] last_road_temp;
   logic [7:0]  last_road_cond;

   // reflected CRC-16, one byte
   function automatic logic [15:0] modbus_crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = (r >> 1) ^ ({16{r[0]}} & CRC_POLY);
      return r;
   endfunction

   function automatic logic [15:0] crc_over_frame(input int n);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < n; i++) c = modbus_crc_step(c, frame_bytes[i]);
      return c;
   endfunction

   function automatic logic [31:0] rx_word(input int ofs);
      return {rx_frame[ofs + 3], rx_frame[ofs + 2], rx_frame[ofs + 1], rx_frame[ofs]};
   endfunction

   function automatic void frame_restart();
      rx_crc = CRC_INIT;
      rx_count = 0;
      rx_tail[0] = 8'h00;
      rx_tail[1] = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) rx_frame[i] = 8'h00;
   endfunction

   // advance the predicted frame by one accepted byte; queue a result on the last byte
   function automatic void frame_byte_absorb(input rx_item_type it);
      sensor_report_type rep;
      logic [15:0]       stored;
      if (rx_count < MAX_FRAME) begin
         // the newest two bytes stay out of the CRC
         if (rx_count >= 2) rx_crc = modbus_crc_step(rx_crc, rx_tail[0]);
         rx_tail[0] = rx_tail[1];
         rx_tail[1] = it.data;
         if (rx_count < FRAME_BYTES) rx_frame[rx_count] = it.data;
         rx_count++;
      end
      if (!it.last) return;

      stored = {rx_frame[OFS_CRC + 1], rx_frame[OFS_CRC]};
      rep.crc_ok = (stored == rx_crc);
      rep.air_status = rx_frame[OFS_AIR_ERR];
      rep.road_status = rx_frame[OFS_ROAD_ERR];
      if (rep.crc_ok) begin
         if (rep.air_status == 8'h00) begin
            last_air_temp = rx_word(OFS_AIR_TEMP);
            last_air_humi = rx_word(OFS_AIR_HUMI);
         end
         if (rep.road_status == 8'h00) begin
            last_road_temp = rx_word(OFS_ROAD_TEMP);
            last_road_cond = rx_frame[OFS_ROAD_COND];
         end
      end else begin
         rep.air_status = STATUS_CRC_FAIL;
         rep.road_status = STATUS_CRC_FAIL;
      end
      rep.air_temp = last_air_temp;
      rep.air_humi = last_air_humi;
      rep.road_temp = last_road_temp;
      rep.road_state = last_road_cond;
      expected_reports.push_back(it.typed ? it.exp : rep);
      frame_restart();
   endfunction

   // req side: bursts of random length, random gaps between them
   rx_item_type offered;
   int          burst_left = 0;
   int          gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tlast <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_byte_absorb(offered);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_plan.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               offered = byte_plan.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offered.data;
               req_tlast <= offered.last;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // rsp side: stall pattern in stretches, a long hold on request, and the result check
   int                hold_left  = 0;
   stall_mode_type    stall_mode = STALL_NONE;
   int                mode_left  = 0;
   sensor_report_type want;
   sensor_report_type got;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_reports.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected result ok=%0b data=%030h", rsp_tuser, rsp_tdata);
            end else begin
               want = expected_reports.pop_front();
               if (want.crc_ok) reports_ok++;
               else reports_flagged++;
               if (got.crc_ok !== want.crc_ok || got.air_status !== want.air_status ||
                   got.road_status !== want.road_status || got.air_temp !== want.air_temp ||
                   got.air_humi !== want.air_humi || got.road_temp !== want.road_temp ||
                   got.road_state !== want.road_state) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10) begin
                     $display({"mismatch exp: ok=%0b air=%02h road=%02h",
                               " at=%08h ah=%08h rt=%08h rs=%02h"},
                              want.crc_ok, want.air_status, want.road_status, want.air_temp,
                              want.air_humi, want.road_temp, want.road_state);
                     $display({"         got: ok=%0b air=%02h road=%02h",
                               " at=%08h ah=%08h rt=%08h rs=%02h"},
                              got.crc_ok, got.air_status, got.road_status, got.air_temp,
                              got.air_humi, got.road_temp, got.road_state);
                  end
               end
            end
         end

         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_stall_req) begin
            hold_left = LONG_HOLD;
            long_stall_req <= 1'b0;
            long_holds++;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE: rsp_tready <= 1'b1;
               STALL_HALF: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   task automatic plan_item(input logic [7:0] b, input logic last, input bit typed,
                            input sensor_report_type exp);
      rx_item_type it;
      it.data = b;
      it.last = last;
      it.typed = typed;
      it.exp = exp;
      byte_plan.push_back(it);
      bytes_planned++;
   endtask

   task automatic plan_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         plan_item(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_REPORT);
      frames_planned++;
   endtask

   // 23-byte frame with a correct CRC word; error bytes mostly zero
   task automatic build_checked_frame();
      logic [15:0] c;
      frame_bytes.delete();
      for (int i = 0; i < OFS_CRC; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes[OFS_ROAD_ERR] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                               : 8'h00;
      frame_bytes[OFS_AIR_ERR] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                              : 8'h00;
      c = crc_over_frame(OFS_CRC);
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endtask

   // wait until every planned byte went in and every result came out
   task automatic wait_all_reported();
      while (bytes_accepted != bytes_planned || expected_reports.size() != 0) @(posedge clock);
   endtask

   initial begin
      // short frames after reset, then one good frame at field extremes
      directed_rows = '{
         '{8'h00, 1'b1, SRC_BYTE, 1'b1, CRC_FAIL_EMPTY},
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h5A, 1'b1, SRC_BYTE, 1'b1, CRC_FAIL_EMPTY},
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h00, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'hAA, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h55, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h80, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h7F, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h00, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},   // road error
         '{8'h01, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},   // road temperature
         '{8'h02, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h03, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h80, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},   // road condition
         '{8'h00, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},   // air error
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},   // air temperature
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'hFF, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h12, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},   // humidity
         '{8'h34, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h56, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h78, 1'b0, SRC_BYTE, 1'b0, NO_REPORT},
         '{8'h00, 1'b0, SRC_CRC_LO, 1'b0, NO_REPORT},
         '{8'h00, 1'b1, SRC_CRC_HI, 1'b1, GOOD_FRAME_EXP}
      };
   end

   initial begin
      logic [15:0]    tx_crc;
      logic [15:0]    c;
      logic [7:0]     b;
      frame_kind_type kind;
      int             pick;
      bit             hit;

      last_air_temp = '0;
      last_air_humi = '0;
      last_road_temp = '0;
      last_road_cond = '0;
      frame_restart();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; CRC rows take the word over the bytes sent so far
      tx_crc = CRC_INIT;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         case (directed_rows[r].src)
            SRC_CRC_LO: b = tx_crc[7:0];
            SRC_CRC_HI: b = tx_crc[15:8];
            default: begin
               b = directed_rows[r].data;
               tx_crc = modbus_crc_step(tx_crc, b);
            end
         endcase
         plan_item(b, directed_rows[r].last, directed_rows[r].typed, directed_rows[r].exp);
         if (directed_rows[r].last) begin
            tx_crc = CRC_INIT;
            frames_planned++;
         end
      end
      wait_all_reported();
      drains++;

      // random frames of five kinds, good ones the most common
      while (bytes_planned < DIRECTED_ROWS + RANDOM_BYTES) begin
         while (byte_plan.size() > PLAN_DEPTH) @(posedge clock);
         pick = $urandom_range(0, 99);
         kind = (pick < 45) ? FR_GOOD : (pick < 60) ? FR_CORRUPT : (pick < 72) ? FR_SHORT :
                (pick < 85) ? FR_LONG : FR_TAIL;
         case (kind)
            FR_GOOD: build_checked_frame();
            FR_CORRUPT: begin
               build_checked_frame();
               pick = $urandom_range(0, FRAME_BYTES - 1);
               frame_bytes[pick] = frame_bytes[pick] ^ (8'h01 << $urandom_range(0, 7));
            end
            FR_SHORT: begin
               frame_bytes.delete();
               repeat ($urandom_range(1, FRAME_BYTES - 1))
                  frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            FR_LONG: begin
               // past the capture window and often past the frame limit
               frame_bytes.delete();
               repeat ($urandom_range(FRAME_BYTES + 1, MAX_FRAME + 16))
                  frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               // 24 bytes: the CRC covers byte 21, so look for a byte that agrees
               // with its own CRC low half
               build_checked_frame();
               void'(frame_bytes.pop_back());
               void'(frame_bytes.pop_back());
               hit = 1'b0;
               for (int v = 0; v < 256 && !hit; v++) begin
                  c = modbus_crc_step(crc_over_frame(OFS_CRC), v[7:0]);
                  if (c[7:0] == v[7:0]) begin
                     hit = 1'b1;
                     frame_bytes.push_back(v[7:0]);
                     frame_bytes.push_back(c[15:8]);
                  end
               end
               if (!hit) begin
                  frame_bytes.push_back(8'($urandom_range(0, 255)));
                  frame_bytes.push_back(8'($urandom_range(0, 255)));
               end
               frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
         endcase
         plan_frame();

         // long receiver hold while the plan is full, and sender pauses to drain
         if (frames_planned == 15 || frames_planned == 42) long_stall_req <= 1'b1;
         if (frames_planned == 28 || frames_planned == 56) begin
            wait_all_reported();
            drains++;
         end
      end

      wait_all_reported();
      repeat (8) @(posedge clock);

      $display("Covered %0d bytes in %0d frames: %0d results with good CRC, %0d flagged;",
               bytes_accepted, frames_planned, reports_ok, reports_flagged);
      $display("short, long, corrupted and tail-checked frames, %0d long holds, %0d drains.",
               long_holds, drains);
      if (mismatch_cnt == 0 && expected_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatch_cnt);
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 400000);
      $display("timeout with %0d results outstanding", expected_reports.size());
      $display("Verification failed");
      $finish;
   end

endmodule
